// File: design/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the tween slot table: widths, result kinds,
// fixed-point constants and the result word layout.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int SLOTS       = 8;
    localparam int FRAC_BITS   = 6;
    localparam int MAX_RESULTS = 8;

    localparam int VAL_W    = 16;
    localparam int FRAMES_W = 9;
    localparam int TAG_W    = 7;
    localparam int SLOT_W   = 3;
    localparam int KIND_W   = 2;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCNT_W = $clog2(SLOTS + 1);
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic signed [VAL_W-1:0] FIX_ONE   = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] FIX_TWO   = VAL_W'(2 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] FIX_THREE = VAL_W'(3 << FRAC_BITS);

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_START_OK   = 2'd0,
        KIND_START_FULL = 2'd1,
        KIND_UPDATE     = 2'd2,
        KIND_IDLE_TICK  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [SLOT_W-1:0]        slot;
        logic [TAG_W-1:0]         tag;
        logic signed [VAL_W-1:0]  value;
        logic                     fin;
    } t_res;

endpackage

// File: design/tws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_if
// Valid/ready channels of the tween slot table: command words in, result
// words out.
// ----------------------------------------------------------------------------
interface tws_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic                                 smooth;
    logic [tws_pkg::FRAMES_W-1:0]         frame_total;
    logic [tws_pkg::TAG_W-1:0]            tag;
    logic signed [tws_pkg::VAL_W-1:0]     start_value;
    logic signed [tws_pkg::VAL_W-1:0]     end_value;

    modport source (output valid, action, smooth, frame_total, tag, start_value, end_value,
                    input ready);
    modport sink   (input valid, action, smooth, frame_total, tag, start_value, end_value,
                    output ready);
endinterface

interface tws_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [tws_pkg::KIND_W-1:0]           result_kind;
    logic [tws_pkg::SLOT_W-1:0]           slot;
    logic [tws_pkg::TAG_W-1:0]            tag_out;
    logic signed [tws_pkg::VAL_W-1:0]     value_out;
    logic                                 finished;
    logic                                 last;

    modport source (output valid, result_kind, slot, tag_out, value_out, finished, last,
                    input ready);
    modport sink   (input valid, result_kind, slot, tag_out, value_out, finished, last,
                    output ready);
endinterface

// File: design/fixed_point_tween_slots_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_tween_slots_top
// Table of animation slots interpolating 16-bit fixed-point values, linear or
// smoothstep, advanced one frame per tick word.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  i_in    | in  | action, smooth, frame_total, tag, start_value, end_value
//  o_out   | out | result_kind, slot, tag_out, value_out, finished, last
//
//  a start word searches for the lowest free slot, one slot a cycle
//  a tick word runs busy slots through the bit-serial divider and the
//  single shared multiplier
//  ready is low while a word is in work; o_out stalls hold the sequencer
//  reset is synchronous, active low, and frees every slot at once
// ----------------------------------------------------------------------------
module fixed_point_tween_slots_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tws_in_if.sink        i_in,
    tws_out_if.source     o_out
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        MS_SQ = 3'd0,
        MS_Y  = 3'd1,
        MS_V  = 3'd2,
        MS_HI = 3'd3,
        MS_LO = 3'd4
    } t_mstep;

    localparam int VW = tws_pkg::VAL_W;
    localparam int FW = tws_pkg::FRAMES_W;

    // slot table
    logic                       r_busy   [tws_pkg::SLOTS];
    logic                       r_smooth [tws_pkg::SLOTS];
    logic [tws_pkg::TAG_W-1:0]  r_tag    [tws_pkg::SLOTS];
    logic signed [VW-1:0]       r_startv [tws_pkg::SLOTS];
    logic signed [VW-1:0]       r_endv   [tws_pkg::SLOTS];
    logic [FW-1:0]              r_frames [tws_pkg::SLOTS];
    logic [FW-1:0]              r_framec [tws_pkg::SLOTS];

    t_state                     r_state, n_state;
    t_mstep                     r_mstep, n_mstep;
    logic [tws_pkg::SCNT_W-1:0] r_idx, n_idx;
    logic [tws_pkg::RCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_pend_v, n_pend_v;
    tws_pkg::t_res              r_pend, n_pend;
    tws_pkg::t_res              r_new, n_new;
    logic                       r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    tws_pkg::t_res              r_out, n_out;
    logic                       r_out_last, n_out_last;

    logic                       r_in_smooth, n_in_smooth;
    logic [FW-1:0]              r_in_frames, n_in_frames;
    logic [tws_pkg::TAG_W-1:0]  r_in_tag, n_in_tag;
    logic signed [VW-1:0]       r_in_start, n_in_start;
    logic signed [VW-1:0]       r_in_end, n_in_end;

    logic [FW-1:0]              r_frame, n_frame;
    logic signed [VW-1:0]       r_v, n_v;
    logic signed [VW-1:0]       r_sq, n_sq;
    logic signed [VW-1:0]       r_y, n_y;
    logic signed [VW-1:0]       r_acc, n_acc;

    logic [tws_pkg::IDX_W-1:0]  idx;
    logic                       busy_rd;
    logic                       smooth_rd;
    logic [tws_pkg::TAG_W-1:0]  tag_rd;
    logic signed [VW-1:0]       start_rd;
    logic signed [VW-1:0]       end_rd;
    logic [FW-1:0]              frames_rd;
    logic [FW-1:0]              frame_rd;

    logic                       wr_start;
    logic                       wr_frame;
    logic                       clr_busy;
    logic                       out_free;
    logic                       idx_end;
    logic                       div_start;
    logic                       div_done;
    logic signed [VW-1:0]       div_q;
    logic signed [VW-1:0]       div_num;
    logic signed [VW-1:0]       div_den;

    logic signed [VW-1:0]       mul_a, mul_b;
    logic signed [2*VW-1:0]     mul_p;
    logic signed [VW-1:0]       prod;
    logic signed [VW-1:0]       val_sum;
    logic [tws_pkg::SLOT_W-1:0] slot_id;

    assign idx       = r_idx[tws_pkg::IDX_W-1:0];
    assign busy_rd   = r_busy[idx];
    assign smooth_rd = r_smooth[idx];
    assign tag_rd    = r_tag[idx];
    assign start_rd  = r_startv[idx];
    assign end_rd    = r_endv[idx];
    assign frames_rd = r_frames[idx];
    assign frame_rd  = r_framec[idx];
    assign slot_id   = tws_pkg::SLOT_W'(r_idx);
    assign idx_end   = (r_idx == tws_pkg::SCNT_W'(tws_pkg::SLOTS));
    assign out_free  = !r_out_valid || o_out.ready;

    assign div_num = VW'({n_frame, {tws_pkg::FRAC_BITS{1'b0}}});
    assign div_den = VW'({frames_rd, {tws_pkg::FRAC_BITS{1'b0}}});

    tws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // shared multiplier, product floored by the fraction shift
    always_comb begin
        unique case (r_mstep)
            MS_SQ:   begin mul_a = r_v;                  mul_b = r_v;                  end
            MS_Y:    begin mul_a = tws_pkg::FIX_TWO;     mul_b = r_v;                  end
            MS_V:    begin mul_a = r_sq;                 mul_b = r_y;                  end
            MS_HI:   begin mul_a = end_rd;               mul_b = r_v;                  end
            MS_LO:   begin mul_a = start_rd;             mul_b = tws_pkg::FIX_ONE - r_v; end
            default: begin mul_a = '0;                   mul_b = '0;                   end
        endcase
        mul_p   = mul_a * mul_b;
        prod    = VW'(mul_p >>> tws_pkg::FRAC_BITS);
        val_sum = r_acc + prod;
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mstep     = r_mstep;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_new       = r_new;
        n_res       = 1'b0;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_in_smooth = r_in_smooth;
        n_in_frames = r_in_frames;
        n_in_tag    = r_in_tag;
        n_in_start  = r_in_start;
        n_in_end    = r_in_end;
        n_frame     = r_frame;
        n_v         = r_v;
        n_sq        = r_sq;
        n_y         = r_y;
        n_acc       = r_acc;
        wr_start    = 1'b0;
        wr_frame    = 1'b0;
        clr_busy    = 1'b0;
        div_start   = 1'b0;

        // hand the held result on once the next one is known
        if (r_res && (!r_pend_v || out_free)) begin
            if (r_pend_v) begin
                n_out       = r_pend;
                n_out_last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend   = r_new;
            n_pend_v = 1'b1;
            clr_busy = r_new.fin;
            n_idx    = r_idx + tws_pkg::SCNT_W'(1);
            n_cnt    = r_cnt + tws_pkg::RCNT_W'(1);
            n_state  = S_SCAN;
        end else if (r_res) begin
            n_res = 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        n_in_smooth = i_in.smooth;
                        n_in_frames = i_in.frame_total;
                        n_in_tag    = i_in.tag;
                        n_in_start  = i_in.start_value;
                        n_in_end    = i_in.end_value;
                        n_idx       = '0;
                        n_cnt       = '0;
                        n_pend_v    = 1'b0;
                        n_state     = (i_in.action == tws_pkg::ACT_START) ? S_FIND : S_SCAN;
                    end
                end
                S_FIND: begin
                    priority if (idx_end) begin
                        n_pend   = '{tws_pkg::KIND_START_FULL, '0, r_in_tag, '0, 1'b0};
                        n_pend_v = 1'b1;
                        n_state  = S_FLUSH;
                    end else if (!busy_rd) begin
                        wr_start = 1'b1;
                        n_pend   = '{tws_pkg::KIND_START_OK, slot_id, r_in_tag, r_in_start,
                                     1'b0};
                        n_pend_v = 1'b1;
                        n_state  = S_FLUSH;
                    end else begin
                        n_idx = r_idx + tws_pkg::SCNT_W'(1);
                    end
                end
                S_SCAN: begin
                    priority if (idx_end || r_cnt == tws_pkg::RCNT_W'(tws_pkg::MAX_RESULTS)) begin
                        if (!r_pend_v) begin
                            n_pend = '{tws_pkg::KIND_IDLE_TICK, '0, '0, '0, 1'b0};
                        end
                        n_pend_v = 1'b1;
                        n_state  = S_FLUSH;
                    end else if (!busy_rd) begin
                        n_idx = r_idx + tws_pkg::SCNT_W'(1);
                    end else begin
                        n_frame  = frame_rd + FW'(1);
                        wr_frame = 1'b1;
                        if (frames_rd == '0) begin
                            n_new = '{tws_pkg::KIND_UPDATE, slot_id, tag_rd, end_rd, 1'b1};
                            n_res = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        n_v     = div_q;
                        n_mstep = smooth_rd ? MS_SQ : MS_HI;
                        n_state = S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_mstep)
                        MS_SQ: begin
                            n_sq    = prod;
                            n_mstep = MS_Y;
                        end
                        MS_Y: begin
                            n_y     = tws_pkg::FIX_THREE - prod;
                            n_mstep = MS_V;
                        end
                        MS_V: begin
                            n_v     = prod;
                            n_mstep = MS_HI;
                        end
                        MS_HI: begin
                            n_acc   = prod;
                            n_mstep = MS_LO;
                        end
                        MS_LO: begin
                            n_new = '{tws_pkg::KIND_UPDATE, slot_id, tag_rd, val_sum,
                                      (val_sum >= end_rd) || (r_frame >= frames_rd)};
                            n_res = 1'b1;
                        end
                        default: begin
                            n_mstep = MS_SQ;
                        end
                    endcase
                end
                S_FLUSH: begin
                    if (out_free) begin
                        n_out       = r_pend;
                        n_out_last  = 1'b1;
                        n_out_valid = 1'b1;
                        n_pend_v    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mstep     <= MS_SQ;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_pend_v    <= 1'b0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < tws_pkg::SLOTS; i++) begin
                r_busy[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_mstep     <= n_mstep;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_pend_v    <= n_pend_v;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
            if (wr_start) begin
                r_busy[idx] <= 1'b1;
            end else if (clr_busy) begin
                r_busy[idx] <= 1'b0;
            end
        end
        r_pend      <= n_pend;
        r_new       <= n_new;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
        r_in_smooth <= n_in_smooth;
        r_in_frames <= n_in_frames;
        r_in_tag    <= n_in_tag;
        r_in_start  <= n_in_start;
        r_in_end    <= n_in_end;
        r_frame     <= n_frame;
        r_v         <= n_v;
        r_sq        <= n_sq;
        r_y         <= n_y;
        r_acc       <= n_acc;
        if (wr_start) begin
            r_smooth[idx] <= r_in_smooth;
            r_tag[idx]    <= r_in_tag;
            r_startv[idx] <= r_in_start;
            r_endv[idx]   <= r_in_end;
            r_frames[idx] <= r_in_frames;
            r_framec[idx] <= '0;
        end else if (wr_frame) begin
            r_framec[idx] <= n_frame;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.kind;
    assign o_out.slot        = r_out.slot;
    assign o_out.tag_out     = r_out.tag;
    assign o_out.value_out   = r_out.value;
    assign o_out.finished    = r_out.fin;
    assign o_out.last        = r_out_last;

    // divider only reports while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide step");

    // a finished flag only rides on a slot update
    a_fin_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.finished) |-> (o_out.result_kind == tws_pkg::KIND_UPDATE))
        else $error("finished on a non-update word");

    // start answers and idle ticks are single words
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind != tws_pkg::KIND_UPDATE) |-> o_out.last)
        else $error("single-word result without last");

    // never more updates than the result limit in one tick
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tws_pkg::RCNT_W'(tws_pkg::MAX_RESULTS))
        else $error("result count over limit");

endmodule

// File: design/tws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_div
// Fixed-point divider: (num << FRAC_BITS) / den, truncated toward zero,
// wrapped to 16 bits; one quotient bit per cycle, zero divisor gives 1.0.
// ----------------------------------------------------------------------------
module tws_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tws_pkg::VAL_W-1:0]    i_num,
    input  logic signed [tws_pkg::VAL_W-1:0]    i_den,
    output logic                                o_done,
    output logic signed [tws_pkg::VAL_W-1:0]    o_quot
);

    localparam int NUM_W = tws_pkg::VAL_W + tws_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_neg, n_neg;
    logic [NUM_W-1:0]               r_num, n_num;
    logic [NUM_W-1:0]               r_q, n_q;
    logic [tws_pkg::VAL_W-1:0]      r_rem, n_rem;
    logic [tws_pkg::VAL_W-1:0]      r_den, n_den;
    logic signed [tws_pkg::VAL_W-1:0] r_quot, n_quot;

    logic signed [NUM_W-1:0]        num_ext;
    logic [tws_pkg::VAL_W:0]        rem_sh;
    logic [tws_pkg::VAL_W:0]        rem_sub;
    logic                           q_bit;
    logic [NUM_W-1:0]               q_next;
    logic [NUM_W-1:0]               q_signed;

    always_comb begin
        num_ext  = {i_num, {tws_pkg::FRAC_BITS{1'b0}}};
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, r_den};
        q_bit    = (rem_sh >= {1'b0, r_den});
        q_next   = {r_q[NUM_W-2:0], q_bit};
        q_signed = r_neg ? (~q_next + NUM_W'(1)) : q_next;

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_num  = r_num;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;

        if (i_start) begin
            if (i_den == '0) begin
                n_quot = tws_pkg::FIX_ONE;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_cnt  = CNT_W'(NUM_W);
                n_neg  = i_num[tws_pkg::VAL_W-1] ^ i_den[tws_pkg::VAL_W-1];
                n_num  = num_ext[NUM_W-1] ? (~num_ext + NUM_W'(1)) : num_ext;
                n_den  = i_den[tws_pkg::VAL_W-1] ? (~i_den + tws_pkg::VAL_W'(1)) : i_den;
                n_q    = '0;
                n_rem  = '0;
            end
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_q   = q_next;
            n_rem = q_bit ? rem_sub[tws_pkg::VAL_W-1:0] : rem_sh[tws_pkg::VAL_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_quot = q_signed[tws_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg  <= n_neg;
        r_num  <= n_num;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
